// File: sv/ptwa_pkg.sv
// ----------------------------------------------------------------------------
// ptwa_pkg: shared types and constants of the peer table with aging
// Item layouts, table entry layout, event codes and controller states.
// ----------------------------------------------------------------------------
package ptwa_pkg;

  localparam int TABLE_ENTRIES_DEF = 16;
  localparam logic [2:0] LIFETIME_DEF = 3'd6;
  localparam int CFG_ADDR_W = 3;
  localparam logic REG_LIFETIME = 1'b0;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_ANNOUNCE = 1'b1;

  localparam logic [2:0] EV_NEW = 3'd0;
  localparam logic [2:0] EV_REFRESH = 3'd1;
  localparam logic [2:0] EV_EXPIRED = 3'd2;
  localparam logic [2:0] EV_DROPPED = 3'd3;
  localparam logic [2:0] EV_TICK_DONE = 3'd4;

  typedef struct packed {
    logic        opcode;
    logic [31:0] source_addr;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [31:0] peer_addr;
    logic [4:0]  live_count;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic        valid;
    logic [2:0]  count;
    logic [31:0] key;
  } entry_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

endpackage

// File: sv/ptwa_cell.sv
// ----------------------------------------------------------------------------
// ptwa_cell: one table slot of the rotating entry chain
// Holds one entry; takes its neighbor's entry on shift, or a new one on load.
// ----------------------------------------------------------------------------
module ptwa_cell import ptwa_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  entry_t     shift_in,
  input  entry_t     load_in,
  output entry_t     q
);

  logic        valid;
  logic [2:0]  count;
  logic [31:0] key;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      count <= 3'd0;
    end else if (ctrl.load) begin
      valid <= load_in.valid;
      count <= load_in.count;
    end else if (ctrl.shift) begin
      valid <= shift_in.valid;
      count <= shift_in.count;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      key <= load_in.key;
    end else if (ctrl.shift) begin
      key <= shift_in.key;
    end
  end

  assign q = '{valid: valid, count: count, key: key};

endmodule

// File: sv/ptwa_regs.sv
// ----------------------------------------------------------------------------
// ptwa_regs: configuration register file
// APB-style write and read access to the lifetime reload register.
// ----------------------------------------------------------------------------
module ptwa_regs import ptwa_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output logic [2:0]            lifetime
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite && (paddr[2] == REG_LIFETIME);

  always_ff @(posedge clk) begin
    if (rst) begin
      lifetime <= LIFETIME_DEF;
    end else if (wr_en) begin
      lifetime <= pwdata[2:0];
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == REG_LIFETIME) begin
      prdata = {29'd0, lifetime};
    end
  end

endmodule

// File: sv/peer_table_with_aging.sv
// ----------------------------------------------------------------------------
// peer_table_with_aging: peer presence table with lifetime aging
// For each item, idle takes the item, then the entry chain rotates one slot
// per cycle past a single update stage while no expiry result is held up, so
// a full pass visits every slot in order, and a final state then issues the
// final result and performs any insert. A result that meets a full output
// register holds the rotation, or the final state, for as long as the
// register stays full. The next item is taken once the final result is in
// the output register.
// Announces reload a known peer, insert an unknown one into the lowest free
// slot, or are dropped when the table is full; ticks age every entry and
// report expiries in slot order, then a tick-done result.
// ----------------------------------------------------------------------------
module peer_table_with_aging import ptwa_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int LIVE_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  state_t state, state_next;

  logic [2:0]        lifetime;
  logic              op;
  logic [31:0]       addr;
  logic [IDX_W-1:0]  idx;
  logic              hit;
  logic              free_found;
  logic [IDX_W-1:0]  free_idx;
  logic [LIVE_W-1:0] live;

  entry_t cells [TABLE_ENTRIES];
  entry_t head;
  entry_t proc_entry;
  entry_t ins_entry;

  logic [2:0]  cnt_dec;
  logic        expire;
  logic        hit_here;
  logic        need_emit;
  logic        out_free;
  logic        advance;
  logic        load_out;
  logic        insert;
  out_item_t   out_next;
  logic [LIVE_W-1:0] live_res;

  function automatic logic [4:0] live_field(input logic [LIVE_W-1:0] v);
    logic [LIVE_W+4:0] w;
    w = (LIVE_W + 5)'(v);
    return w[4:0];
  endfunction

  ptwa_regs u_regs (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .lifetime (lifetime)
  );

  assign head = cells[0];
  assign ins_entry = '{valid: 1'b1, count: lifetime, key: addr};

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    entry_t     sin;
    cell_ctrl_t ctrl;
    if (i == TABLE_ENTRIES - 1) begin : g_tail
      assign sin = proc_entry;
    end else begin : g_mid
      assign sin = cells[i+1];
    end
    assign ctrl.shift = advance;
    assign ctrl.load = insert && (free_idx == IDX_W'(i));
    ptwa_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .shift_in (sin),
      .load_in  (ins_entry),
      .q        (cells[i])
    );
  end

  // update stage at the head of the chain
  always_comb begin
    cnt_dec = head.count - 3'd1;
    expire = (cnt_dec == 3'd0);
    hit_here = head.valid && (head.key == addr);
    proc_entry = head;
    need_emit = 1'b0;
    if (op == OP_TICK) begin
      if (head.valid) begin
        proc_entry.count = cnt_dec;
        proc_entry.valid = !expire;
        need_emit = expire;
      end
    end else if (hit_here) begin
      proc_entry.count = lifetime;
    end
  end

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (advance && idx == LAST_IDX) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    advance = 1'b0;
    load_out = 1'b0;
    insert = 1'b0;
    live_res = live;
    out_next = '{event_res: EV_TICK_DONE, peer_addr: 32'd0, live_count: 5'd0, last: 1'b1};
    case (state)
      ST_SCAN: begin
        advance = !need_emit || out_free;
        if (need_emit && out_free) begin
          load_out = 1'b1;
          live_res = live - LIVE_W'(1);
          out_next.event_res = EV_EXPIRED;
          out_next.peer_addr = head.key;
          out_next.last = 1'b0;
        end
      end
      ST_FINISH: begin
        load_out = out_free;
        if (op == OP_ANNOUNCE) begin
          out_next.peer_addr = addr;
          if (hit) begin
            out_next.event_res = EV_REFRESH;
          end else if (free_found) begin
            out_next.event_res = EV_NEW;
            live_res = live + LIVE_W'(1);
            insert = out_free;
          end else begin
            out_next.event_res = EV_DROPPED;
          end
        end
      end
      default: begin
      end
    endcase
    out_next.live_count = live_field(live_res);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
      live <= '0;
      idx <= '0;
      hit <= 1'b0;
      free_found <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
        live <= live_res;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (in_valid && in_ready) begin
        idx <= '0;
        hit <= 1'b0;
        free_found <= 1'b0;
      end else if (advance) begin
        idx <= idx + IDX_W'(1);
        if (op == OP_ANNOUNCE) begin
          if (hit_here) begin
            hit <= 1'b1;
          end
          if (!head.valid && !free_found) begin
            free_found <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op <= in_data.opcode;
      addr <= in_data.source_addr;
    end
    if (advance && op == OP_ANNOUNCE && !head.valid && !free_found) begin
      free_idx <= idx;
    end
    if (load_out) begin
      out_data <= out_next;
    end
  end

  a_live_bound: assert property (@(posedge clk) disable iff (rst)
    live <= LIVE_W'(TABLE_ENTRIES))
    else $error("live count above table size");

  a_accept_scan: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == ST_SCAN && idx == '0)
    else $error("accepted item did not start a pass");

  a_finish_last: assert property (@(posedge clk) disable iff (rst)
    state == ST_FINISH && out_free |=> out_valid && out_data.last && state == ST_IDLE)
    else $error("final result missing at end of item");

  a_expire_dec: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN && load_out |=> live == $past(live) - LIVE_W'(1)
      && out_data.event_res == EV_EXPIRED && !out_data.last)
    else $error("expiry report out of step with live count");

  a_insert_free: assert property (@(posedge clk) disable iff (rst)
    insert |-> !hit && live < LIVE_W'(TABLE_ENTRIES))
    else $error("insert into a full table or on a hit");

endmodule
